[src/skt_pkg.sv]
// Package for the sorted key table: field widths, command and status codes,
// and the sequencer state type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int CMD_W  = 2;
    localparam int KEY_W  = 32;
    localparam int NAME_W = 64;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_EV,
        S_INS_PUT,
        S_FND_RD,
        S_FND_EV,
        S_SHF_RD,
        S_SHF_EV
    } state_t;

endpackage

`default_nettype wire

[src/skt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/sorted_key_table.sv]
// Sorted key table top level: sequencer, shared key comparator and two RAMs.
// Depends on skt_pkg and skt_ram.
//
// Usage
//   A transaction is taken when start is high and busy is low. command selects
//   insert, search or remove; item_key is the signed key, name_tag the 64-bit
//   tag stored on insert. Each transaction gives one result: done is high for
//   exactly one cycle with status, found_name and entry_count valid. The
//   receiver cannot stall; the result is simply presented for that cycle.
// Operation
//   Entries sit in ascending key order in a key RAM and a name RAM. One key
//   comparator is stepped over the entries; each entry visited takes a RAM
//   read state, then a compare/move state, as the read port is registered.
//   Insert walks down from the top entry shifting larger keys up. Search walks
//   up from the bottom. Remove finds, then shifts the rest down. A full insert,
//   a search or remove on an empty table and an unused command are answered
//   from idle without a walk.
//   busy stays high for the whole walk; a new transaction may be given in the
//   cycle that done is high.
// Reset
//   rst_n clears the entry count and the sequencer; the RAMs are not cleared
//   as only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_table #(
    parameter int DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [skt_pkg::CMD_W-1:0]   command,
    input  wire logic signed [skt_pkg::KEY_W-1:0] item_key,
    input  wire logic [skt_pkg::NAME_W-1:0]  name_tag,
    output logic                             done,
    output logic [skt_pkg::ST_W-1:0]         status,
    output logic [skt_pkg::NAME_W-1:0]       found_name,
    output logic [skt_pkg::CNT_W-1:0]        entry_count
);

    import skt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 1;

    state_t state_reg, state_next;

    logic [AW-1:0]           idx_reg, idx_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [NAME_W-1:0]       tag_reg, tag_next;
    logic                    done_reg, done_next;
    logic [ST_W-1:0]         status_reg, status_next;
    logic [NAME_W-1:0]       fname_reg, fname_next;

    // RAM ports
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [KEY_W-1:0]        ram_wkey;
    logic [NAME_W-1:0]       ram_wname;
    logic [KEY_W-1:0]        rkey;
    logic [NAME_W-1:0]       rname;

    // Decisions
    logic                    key_gt;
    logic                    key_eq;
    logic                    idx_last;
    logic                    idx_zero;
    logic                    tbl_full;
    logic                    tbl_empty;
    logic [CW-1:0]           cnt_m1;
    logic [CW+CNT_W-1:0]     cnt_ext;

    skt_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wkey),
        .raddr (ram_raddr),
        .rdata (rkey)
    );

    skt_ram #(.WIDTH(NAME_W), .DEPTH(DEPTH)) u_name_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wname),
        .raddr (ram_raddr),
        .rdata (rname)
    );

    // Shared comparator and index tests
    assign key_gt    = $signed(rkey) > key_reg;
    assign key_eq    = $signed(rkey) == key_reg;
    assign idx_last  = (XW'(idx_reg) + XW'(1)) == XW'(count_reg);
    assign idx_zero  = idx_reg == '0;
    assign tbl_full  = count_reg == CW'(DEPTH);
    assign tbl_empty = count_reg == '0;
    assign cnt_m1    = count_reg - CW'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_INSERT:
                        begin
                            if (tbl_full)
                                state_next = S_IDLE;
                            else if (tbl_empty)
                                state_next = S_INS_PUT;
                            else
                                state_next = S_INS_RD;
                        end
                        CMD_SEARCH, CMD_REMOVE:
                        begin
                            if (!tbl_empty)
                                state_next = S_FND_RD;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_INS_RD: state_next = S_INS_EV;
            S_INS_EV:
            begin
                if (!key_gt)
                    state_next = S_IDLE;
                else if (idx_zero)
                    state_next = S_INS_PUT;
                else
                    state_next = S_INS_RD;
            end
            S_INS_PUT: state_next = S_IDLE;
            S_FND_RD:  state_next = S_FND_EV;
            S_FND_EV:
            begin
                if (key_eq)
                begin
                    if (cmd_reg == CMD_REMOVE && !idx_last)
                        state_next = S_SHF_RD;
                    else
                        state_next = S_IDLE;
                end
                else if (idx_last)
                    state_next = S_IDLE;
                else
                    state_next = S_FND_RD;
            end
            S_SHF_RD: state_next = S_SHF_EV;
            S_SHF_EV:
            begin
                if (idx_last)
                    state_next = S_IDLE;
                else
                    state_next = S_SHF_RD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, result and RAM control
    always_comb
    begin
        idx_next    = idx_reg;
        count_next  = count_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        tag_next    = tag_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        fname_next  = fname_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg;
        ram_raddr   = idx_reg;
        ram_wkey    = rkey;
        ram_wname   = rname;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = command;
                    key_next = item_key;
                    tag_next = name_tag;
                    case (command)
                        CMD_INSERT:
                        begin
                            if (tbl_full)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                                fname_next  = '0;
                            end
                            else if (tbl_empty)
                                idx_next = '0;
                            else
                                idx_next = cnt_m1[AW-1:0];
                        end
                        CMD_SEARCH, CMD_REMOVE:
                        begin
                            idx_next = '0;
                            if (tbl_empty)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_NOT_FOUND;
                                fname_next  = '0;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            fname_next  = '0;
                        end
                    endcase
                end
            end
            S_INS_EV:
            begin
                // Larger key moves up one slot; otherwise the new entry lands above it
                ram_we    = 1'b1;
                ram_waddr = idx_reg + AW'(1);
                if (key_gt)
                begin
                    if (!idx_zero)
                        idx_next = idx_reg - AW'(1);
                end
                else
                begin
                    ram_wkey    = key_reg;
                    ram_wname   = tag_reg;
                    count_next  = count_reg + CW'(1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    fname_next  = '0;
                end
            end
            S_INS_PUT:
            begin
                ram_we      = 1'b1;
                ram_wkey    = key_reg;
                ram_wname   = tag_reg;
                count_next  = count_reg + CW'(1);
                done_next   = 1'b1;
                status_next = ST_OK;
                fname_next  = '0;
            end
            S_FND_EV:
            begin
                if (key_eq)
                begin
                    fname_next  = rname;
                    status_next = ST_OK;
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        if (idx_last)
                        begin
                            count_next = cnt_m1;
                            done_next  = 1'b1;
                        end
                        else
                            idx_next = idx_reg + AW'(1);
                    end
                    else
                        done_next = 1'b1;
                end
                else if (idx_last)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    fname_next  = '0;
                end
                else
                    idx_next = idx_reg + AW'(1);
            end
            S_SHF_EV:
            begin
                // Close the gap: entry moves down one slot
                ram_we    = 1'b1;
                ram_waddr = idx_reg - AW'(1);
                if (idx_last)
                begin
                    count_next = cnt_m1;
                    done_next  = 1'b1;
                end
                else
                    idx_next = idx_reg + AW'(1);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        tag_reg    <= tag_next;
        status_reg <= status_next;
        fname_reg  <= fname_next;
    end

    // Outputs
    assign cnt_ext     = {{CNT_W{1'b0}}, count_reg};
    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_name  = fname_reg;
    assign entry_count = cnt_ext[CNT_W-1:0];

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond table depth");

    a_full_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> tbl_full)
        else $error("full status with room left");

    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == CMD_INSERT && tbl_full |=> done && status == ST_FULL)
        else $error("insert into full table not flagged");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done)
        else $error("entry count changed without a result");

endmodule

`default_nettype wire
